// ----- rtl/core/smmv_pkg.sv -----
// Package for the set statistics block: request and result payload types,
// controller states and the command and status structs between the two halves.
// No dependencies.
package smmv_pkg;

  typedef struct packed {
    logic [7:0] mark;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [15:0] mean_q8;
    logic [7:0]  median;
    logic [21:0] variance_q8;
    logic [6:0]  count;
  } res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_MEAN,
    ST_PREP_VAR,
    ST_DIV_VAR,
    ST_SELECT,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the request and update the sums
    logic div_mean;   // start the mean division
    logic prep_var;   // form the variance numerator and denominator
    logic div_var;    // start the variance division
    logic sel_start;  // start the median search
    logic emit;       // present the result and clear the set
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic sel_done;
  } sts_t;

  localparam int unsigned VarMax = 4194303;

endpackage

// ----- rtl/core/set_mean_median_variance_top.sv -----
// Top level of the set statistics block: joins the controller and datapath.
// Depends on smmv_pkg, smmv_ctrl and smmv_dp.
//
// Usage: requests carry one mark and a last flag. A request is taken on a
// rising edge where start is high and busy is low; marks load one per
// cycle. Marks beyond MAX_COUNT are dropped, but their last flag still closes
// the set. After the last mark busy rises and the block computes:
//   mean division   restoring, NW quotient bits, NW = clog2(MAX_COUNT+1) * 2 + 32
//   variance prep, then variance division over NW quotient bits
//   median search   one store read per cycle
// then result_valid_o is high for exactly one cycle with mean, median,
// variance and count, and the block takes requests again. The receiver cannot
// stall; the result must be taken in that cycle. Reset clears the counts and
// sums and returns to loading; the store needs no clearing.
module set_mean_median_variance_top #(
  parameter int unsigned MAX_COUNT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  smmv_pkg::req_t req_i,
  output logic           result_valid_o,
  output smmv_pkg::res_t result_o
);

  smmv_pkg::cmd_t cmd;
  smmv_pkg::sts_t sts;

  smmv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .last_i (req_i.last),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  smmv_dp #(.MAX_COUNT(MAX_COUNT)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i),
    .sts_o (sts),
    .res_o (result_o)
  );

  assign result_valid_o = cmd.emit;

endmodule

// ----- rtl/core/smmv_ctrl.sv -----
// Controller of the set statistics block: sequences loading, the two divisions,
// the median search and the result strobe. Depends on smmv_pkg.
module smmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  smmv_pkg::sts_t    sts_i,
  output smmv_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  smmv_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smmv_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      smmv_pkg::ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = smmv_pkg::ST_DIV_MEAN;
          end
        end
      end
      smmv_pkg::ST_DIV_MEAN: begin
        cmd_o.div_mean = 1'b1;
        if (sts_i.div_done) begin
          state_d = smmv_pkg::ST_PREP_VAR;
        end
      end
      smmv_pkg::ST_PREP_VAR: begin
        cmd_o.prep_var = 1'b1;
        state_d = smmv_pkg::ST_DIV_VAR;
      end
      smmv_pkg::ST_DIV_VAR: begin
        cmd_o.div_var = 1'b1;
        if (sts_i.div_done) begin
          state_d = smmv_pkg::ST_SELECT;
        end
      end
      smmv_pkg::ST_SELECT: begin
        cmd_o.sel_start = 1'b1;
        if (sts_i.sel_done) begin
          state_d = smmv_pkg::ST_EMIT;
        end
      end
      smmv_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = smmv_pkg::ST_LOAD;
      end
      default: state_d = smmv_pkg::ST_LOAD;
    endcase
  end

  // The result strobe is always one cycle and follows the search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !cmd_o.emit)
    else $error("emit held for more than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> $past(state_q) == smmv_pkg::ST_SELECT)
    else $error("emit not preceded by the median search");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("block not busy after the last request");

endmodule

// ----- rtl/core/smmv_dp.sv -----
// Datapath of the set statistics block: mark store, running sums, a shared
// restoring divider and a counting median search. Depends on smmv_pkg.
module smmv_dp #(
  parameter int unsigned MAX_COUNT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  smmv_pkg::cmd_t cmd_i,
  input  smmv_pkg::req_t req_i,
  output smmv_pkg::sts_t sts_o,
  output smmv_pkg::res_t res_o
);

  localparam int unsigned AW  = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int unsigned CW  = $clog2(MAX_COUNT + 1);
  localparam int unsigned SW  = CW + 8;
  localparam int unsigned QW  = SW + 16;
  localparam int unsigned DW  = 2 * CW;
  localparam int unsigned PW  = DW + 16;
  localparam int unsigned NW  = CW + QW + 8;
  localparam int unsigned IW  = $clog2(NW + 1);

  logic [7:0]    mem_q [MAX_COUNT];
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sum_q;
  logic [QW-1:0] sq_q;

  // Mark store and running sums.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q < CW'(MAX_COUNT)) begin
      mem_q[cnt_q[AW-1:0]] <= req_i.mark;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.load && cnt_q < CW'(MAX_COUNT)) begin
      cnt_q <= cnt_q + 1'b1;
      sum_q <= sum_q + SW'(req_i.mark);
      sq_q  <= sq_q + QW'(req_i.mark * req_i.mark);
    end
  end

  // Variance numerator and denominator, formed in one step each. The products
  // are as wide as count squared times the largest square.
  logic [NW-1:0] vnum_q;
  logic [DW-1:0] vden_q;
  logic [PW-1:0] nsq_q;
  logic [PW-1:0] ss_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mean) begin
      nsq_q <= PW'(cnt_q * sq_q);
      ss_q  <= PW'(sum_q * sum_q);
    end
    if (cmd_i.prep_var) begin
      vnum_q <= NW'(nsq_q - ss_q) << 8;
      vden_q <= DW'(cnt_q * cnt_q);
    end
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic          busy_q, done_q;
  logic [IW-1:0] bit_q;
  logic [NW-1:0] num_q, quo_q;
  logic [NW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [NW:0]   trial;
  logic          go;
  assign go    = (cmd_i.div_mean || cmd_i.div_var) && !busy_q && !done_q;
  assign trial = {rem_q, num_q[NW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= busy_q && (bit_q == IW'(1));
      if (go) begin
        busy_q <= 1'b1;
        bit_q  <= IW'(NW);
      end else if (busy_q) begin
        bit_q <= bit_q - 1'b1;
        if (bit_q == IW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rem_q <= '0;
      quo_q <= '0;
      if (cmd_i.div_mean) begin
        num_q <= NW'(sum_q) << 8;
        den_q <= DW'(cnt_q);
      end else begin
        num_q <= vnum_q;
        den_q <= vden_q;
      end
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (trial >= (NW+1)'(den_q)) begin
        rem_q <= NW'(trial - (NW+1)'(den_q));
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial[NW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  // Result capture; a zero count yields zeros, as the divider quotient would not; the variance saturates at VarMax.
  logic [15:0] mean_q;
  logic [21:0] var_q;
  always_ff @(posedge clk_i) begin
    if (done_q && cmd_i.div_mean) begin
      mean_q <= (cnt_q == '0) ? '0 : quo_q[15:0];
    end
    if (done_q && cmd_i.div_var) begin
      if (cnt_q == '0) begin
        var_q <= '0;
      end else if (quo_q > NW'(smmv_pkg::VarMax)) begin
        var_q <= 22'(smmv_pkg::VarMax);
      end else begin
        var_q <= quo_q[21:0];
      end
    end
  end

  // Median search: for each candidate, count marks below it and equal to it,
  // one store entry per cycle. The candidate whose range covers count/2 wins.
  logic [CW-1:0] cand_q, idx_q, lt_q, eq_q;
  logic [CW-1:0] lt_n, eq_n;
  logic [7:0]    cval_q, rd_q, med_q;
  logic          sel_busy_q, sel_done_q, rd_valid_q;
  logic          sel_go, sel_last, sel_hit;
  logic [CW-1:0] half;
  assign half = cnt_q >> 1;

  // Counts including the comparison made in this cycle.
  always_comb begin
    lt_n = lt_q;
    eq_n = eq_q;
    if (rd_valid_q && rd_q < cval_q) lt_n = lt_q + 1'b1;
    if (rd_valid_q && rd_q == cval_q) eq_n = eq_q + 1'b1;
  end

  assign sel_go   = cmd_i.sel_start && !sel_busy_q && !sel_done_q;
  assign sel_last = sel_busy_q && (idx_q == cnt_q);
  assign sel_hit  = sel_last && (half >= lt_n) && (half < lt_n + eq_n);

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[idx_q[AW-1:0]];
    if (idx_q == '0) begin
      cval_q <= mem_q[cand_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_busy_q <= 1'b0;
      sel_done_q <= 1'b0;
      rd_valid_q <= 1'b0;
      cand_q     <= '0;
      idx_q      <= '0;
      lt_q       <= '0;
      eq_q       <= '0;
    end else begin
      sel_done_q <= (sel_go && cnt_q == '0) || sel_hit;
      if (sel_go) begin
        if (cnt_q != '0) begin
          sel_busy_q <= 1'b1;
          cand_q     <= '0;
          idx_q      <= '0;
          lt_q       <= '0;
          eq_q       <= '0;
          rd_valid_q <= 1'b0;
        end
      end else if (sel_busy_q) begin
        if (!sel_last) begin
          // First cycle of a candidate only fetches; later cycles compare.
          rd_valid_q <= 1'b1;
          idx_q      <= idx_q + 1'b1;
          lt_q       <= lt_n;
          eq_q       <= eq_n;
        end else begin
          // All entries compared for this candidate.
          if (sel_hit) begin
            sel_busy_q <= 1'b0;
          end else begin
            cand_q <= cand_q + 1'b1;
          end
          idx_q      <= '0;
          lt_q       <= '0;
          eq_q       <= '0;
          rd_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_last) begin
      med_q <= cval_q;
    end else if (sel_go && cnt_q == '0) begin
      med_q <= '0;
    end
  end

  assign sts_o.div_done = done_q;
  assign sts_o.sel_done = sel_done_q;

  assign res_o.mean_q8     = mean_q;
  assign res_o.median      = med_q;
  assign res_o.variance_q8 = var_q;
  assign res_o.count       = 7'(cnt_q);

  // The divider and the search never run together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && sel_busy_q))
    else $error("divider and median search overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_COUNT))
    else $error("mark count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a division");

endmodule

// ----- tb/tb_set_mean_median_variance_top.sv -----
// Testbench for set_mean_median_variance_top: sends sets of marks and checks each
// result against a predictor of mean, median, population variance and count.
// Depends on smmv_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_set_mean_median_variance_top;

  localparam int unsigned MaxCount = 64;
  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  smmv_pkg::req_t req_i = '0;
  logic result_valid_o;
  smmv_pkg::res_t result_o;

  // Predictor copy of the set being loaded.
  logic [7:0] set_marks[MaxCount];
  int unsigned set_size = 0;
  longint unsigned set_sum = 0;
  longint unsigned set_sqsum = 0;

  smmv_pkg::res_t stats_expected[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned cycles = 0;

  set_mean_median_variance_top #(.MAX_COUNT(MaxCount)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  // Cycle counter with a generous limit on the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Work out the statistics for a closed set and clear the predictor.
  function automatic smmv_pkg::res_t set_statistics();
    smmv_pkg::res_t r;
    logic [7:0] srt[MaxCount];
    logic [7:0] v;
    longint unsigned n, num, q;
    int k;
    n = set_size;
    for (int i = 0; i < MaxCount; i++) srt[i] = set_marks[i];
    for (int i = 1; i < int'(n); i++) begin
      v = srt[i];
      k = i;
      while (k > 0 && srt[k-1] > v) begin
        srt[k] = srt[k-1];
        k--;
      end
      srt[k] = v;
    end
    r = '0;
    if (n != 0) begin
      r.mean_q8 = 16'((set_sum * 256) / n);
      r.median = srt[n/2];
      num = n * set_sqsum - set_sum * set_sum;
      q = (num * 256) / (n * n);
      if (q > smmv_pkg::VarMax) q = smmv_pkg::VarMax;
      r.variance_q8 = 22'(q);
    end
    r.count = 7'(n);
    set_size = 0;
    set_sum = 0;
    set_sqsum = 0;
    return r;
  endfunction

  // Send one request, optionally after a random gap, and update the predictor.
  // The start line stays high after a request so that the next one can follow
  // at once; it drops only for a gap or a drain.
  task automatic send_mark(input logic [7:0] mark, input logic last, input bit gap);
    int unsigned wait_cycles;
    wait_cycles = gap ? $urandom_range(0, 19) : 0;
    if (wait_cycles != 0) begin
      start <= 1'b0;
      repeat (wait_cycles) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{mark: mark, last: last};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (set_size < MaxCount) begin
      set_marks[set_size] = mark;
      set_size++;
      set_sum += mark;
      set_sqsum += mark * mark;
    end
    if (last) stats_expected.push_back(set_statistics());
    requests_sent++;
  endtask

  // Send a whole set of random marks; the mode picks the spread of values.
  task automatic send_set(input int unsigned len, input int unsigned mode, input bit gaps);
    logic [7:0] m;
    bit g;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: m = 8'($urandom);
        1: m = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: m = 8'($urandom_range(120, 135));
        default: m = 8'($urandom_range(0, 3));
      endcase
      g = gaps && ($urandom_range(0, 3) == 0);
      send_mark(m, i == len - 1, g);
    end
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    smmv_pkg::res_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (stats_expected.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, result_o);
        fail_count++;
      end else begin
        e = stats_expected.pop_front();
        if (result_o.mean_q8 !== e.mean_q8) begin
          $display("%0t: mean_q8 expected %0d actual %0d", $time, e.mean_q8, result_o.mean_q8);
          fail_count++;
        end
        if (result_o.median !== e.median) begin
          $display("%0t: median expected %0d actual %0d", $time, e.median, result_o.median);
          fail_count++;
        end
        if (result_o.variance_q8 !== e.variance_q8) begin
          $display("%0t: variance_q8 expected %0d actual %0d", $time, e.variance_q8,
                   result_o.variance_q8);
          fail_count++;
        end
        if (result_o.count !== e.count) begin
          $display("%0t: count expected %0d actual %0d", $time, e.count, result_o.count);
          fail_count++;
        end
      end
    end
  end

  // Stop sending and wait until every expected result has come.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (stats_expected.size() != 0) @(posedge clk_i);
  endtask

  // Extremes: single marks, all zero, all full scale, two marks.
  task automatic test_extremes();
    send_mark(8'h00, 1'b1, 1'b0);
    send_mark(8'hFF, 1'b1, 1'b0);
    send_mark(8'h00, 1'b0, 1'b0);
    send_mark(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) send_mark(8'hFF, i == 2, 1'b0);
    send_mark(8'hAA, 1'b0, 1'b0);
    send_mark(8'h55, 1'b1, 1'b0);
  endtask

  // Store full: exactly MAX_COUNT marks, then more than MAX_COUNT, the extra ones dropped.
  task automatic test_store_full();
    send_set(MaxCount, 1, 1'b0);
    send_set(MaxCount + 3, 0, 1'b0);
  endtask

  // Random sets, mostly short, with random gaps and a full drain now and then.
  task automatic test_random_sets();
    int unsigned len;
    while (requests_sent < 1550) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MaxCount + 2)
                                        : $urandom_range(1, 12);
      send_set(len, $urandom_range(0, 3), $urandom_range(0, 2) != 0);
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    wait_drained();
    test_store_full();
    test_random_sets();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d marks and checked %0d set results, including overfull sets.",
             requests_sent, results_seen);
    if (fail_count == 0 && stats_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
